### src/ibs_pkg.sv
// Package for the interval binned statistics block: action codes, modes and widths.
// Used by the top level; depends on nothing.
package ibs_pkg;
	localparam int DEFAULT_MAX_PERIODS = 256;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		ACT_REPORT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_MEAN   = 2'd0,
		MODE_COUNT  = 2'd1,
		MODE_SUM    = 2'd2,
		MODE_ROLL   = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'd1;
endpackage

### src/ibs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ibs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### src/ibs_div.sv
// Shared restoring divider: unsigned 64 by 64 bit quotient, one bit per cycle.
// No dependencies.
module ibs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done held");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not start");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 7'd0) else $error("divider count underrun");
`endif
endmodule

### src/interval_binned_statistics.sv
// Top level of the interval binned statistics block.
// Depends on ibs_pkg, ibs_ram and ibs_div.
//
// Each accepted item produces exactly one result, and the input is stalled until that
// result has been transferred. A no-op goes straight to the output, a read waits for the
// registered RAM data, a clear zeroes entry 0, and a report reads, updates and writes
// back the entry of its period; a rollover in mode 3 first zeroes the new period.
// In mean mode every report after the first of a period runs the shared divider
// before the write. A report past the current period runs the same divider to find the
// target period, writes zero into each new period, one RAM write per cycle, and is then
// handled like an in-period report; one dropped for overflow goes on to the output.
// An output stall holds the result. After reset entry 0 is zeroed before the first item.
module interval_binned_statistics #(
	parameter int MAX_PERIODS = ibs_pkg::DEFAULT_MAX_PERIODS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ibs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic signed [31:0]              sample_value,
	input  logic [31:0]                     time_tick,
	input  logic [7:0]                      read_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              read_value,
	output logic                            read_valid,
	output logic [8:0]                      period_count,
	output logic                            overflow
);
	import ibs_pkg::*;

	localparam int AW = $clog2(MAX_PERIODS);
	localparam int PW = AW + 1;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DIVT  = 10'b0000000010,
		ST_FILL  = 10'b0000000100,
		ST_RD    = 10'b0000001000,
		ST_RDW   = 10'b0000010000,
		ST_CALC  = 10'b0000100000,
		ST_DIVM  = 10'b0001000000,
		ST_WR    = 10'b0010000000,
		ST_OUT   = 10'b0100000000,
		ST_INIT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [31:0] ilen_q;
	logic [1:0]  mode_q;
	logic [AW-1:0] cur_q;
	logic [31:0] obs_q;
	logic [31:0] last_q;
	logic        ovf_q;
	logic [1:0]  act_q;
	logic [31:0] val_q;
	logic [31:0] time_q;
	logic [7:0]  idx_q;
	logic [PW-1:0] target_q;
	logic [31:0] old_q;
	logic        ridx_ok_q;
	logic signed [63:0] num_q;
	logic        div_go_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	logic        div_start;
	logic [63:0] div_dvd;
	logic [63:0] div_dvs;
	logic        div_done;
	logic [63:0] div_quo;

	logic [31:0] len;
	logic [63:0] end_t;
	logic [32:0] cnt_inc;
	logic [31:0] cnt_m1;
	logic signed [32:0] cnt_m1_s;
	logic signed [33:0] sum_w;
	logic [31:0] sum_sat;
	logic [31:0] cnt_entry;
	logic signed [63:0] mean_num;
	logic        mean_neg;
	logic [63:0] mean_abs;
	logic signed [64:0] mean_q;
	logic [31:0] mean_sat;

	ibs_ram #(.WIDTH(32), .DEPTH(MAX_PERIODS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	ibs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_quo)
	);

	assign len = (ilen_q == 32'd0) ? 32'd1 : ilen_q;
	assign end_t = (64'(cur_q) + 64'd1) * 64'(len);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE) || cfg_valid;
	assign period_count = 9'(32'(cur_q) + 32'd1);
	assign overflow = ovf_q;

	assign cnt_inc = (obs_q == 32'hFFFFFFFF) ? {1'b0, obs_q} : {1'b0, obs_q} + 33'd1;
	assign cnt_m1 = cnt_inc[31:0] - 32'd1;
	assign cnt_m1_s = signed'({1'b0, cnt_m1});
	assign sum_w = 34'(signed'(obs_q)) + 34'(signed'(val_q));
	assign sum_sat = (sum_w > 34'sh7FFFFFFF) ? 32'h7FFFFFFF :
		(sum_w < -34'sh80000000) ? 32'h80000000 : sum_w[31:0];
	assign cnt_entry = (|cnt_inc[32:15]) ? 32'h7FFFFFFF : {cnt_inc[15:0], 16'd0};
	assign mean_num = 64'(signed'(ram_rdata)) * 64'(cnt_m1_s) + 64'(signed'(val_q));
	assign mean_neg = num_q[63];
	assign mean_abs = mean_neg ? (64'd0 - num_q) : num_q;
	assign mean_q = mean_neg ? -65'(signed'({1'b0, div_quo})) : 65'(signed'({1'b0, div_quo}));
	assign mean_sat = (mean_q > 65'sh7FFFFFFF) ? 32'h7FFFFFFF :
		(mean_q < -65'sh80000000) ? 32'h80000000 : mean_q[31:0];

	assign div_start = div_go_q;
	assign div_dvd = mean_abs;
	assign div_dvs = (state_q == ST_DIVM) ? 64'(cnt_inc[31:0]) : 64'(len);

	always_comb begin
		ram_we = 1'b0;
		ram_addr = cur_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = AW'(read_index);
			end
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_RDW: begin
				ram_addr = AW'(idx_q);
			end
			ST_WR: begin
				ram_we = 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_WR && act_q == ACT_REPORT) begin
			if (mode_q == MODE_COUNT) begin
				ram_wdata = cnt_entry;
			end else if (mode_q == MODE_MEAN) begin
				ram_wdata = (cnt_inc[31:0] == 32'd1) ? val_q : old_q;
			end else begin
				ram_wdata = sum_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			ilen_q   <= 32'd1;
			mode_q   <= MODE_MEAN;
			cur_q    <= '0;
			obs_q    <= '0;
			last_q   <= 32'd1;
			ovf_q    <= 1'b0;
			out_valid <= 1'b0;
			div_go_q <= 1'b0;
			act_q    <= '0;
			val_q    <= '0;
			time_q   <= '0;
			idx_q    <= '0;
			target_q <= '0;
			old_q    <= '0;
			ridx_ok_q <= 1'b0;
			num_q    <= '0;
			read_value <= '0;
			read_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: state_q <= ST_IDLE;
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_INTERVAL) begin
							ilen_q <= cfg_data;
							last_q <= cfg_data;
						end else if (cfg_index == REG_MODE) begin
							mode_q <= cfg_data[1:0];
						end
					end else if (in_valid) begin
						act_q  <= action;
						val_q  <= sample_value;
						time_q <= time_tick;
						idx_q  <= read_index;
						ridx_ok_q <= (32'(read_index) <= 32'(cur_q)) &&
							(32'(read_index) < MAX_PERIODS);
						unique case (action_t'(action))
							ACT_READ: state_q <= ST_RDW;
							ACT_CLEAR: begin
								state_q <= ST_WR;
							end
							ACT_NOP: state_q <= ST_OUT;
							ACT_REPORT: begin
								if (mode_q == MODE_ROLL) begin
									if (time_tick < last_q) begin
										if (32'(cur_q) + 32'd1 >= MAX_PERIODS) begin
											ovf_q <= 1'b1;
											state_q <= ST_OUT;
										end else begin
											cur_q <= cur_q + AW'(1);
											obs_q <= '0;
											last_q <= time_tick;
											state_q <= ST_FILL;
										end
									end else begin
										last_q <= time_tick;
										state_q <= ST_RD;
									end
								end else if (64'(time_tick) <= end_t) begin
									state_q <= ST_RD;
								end else begin
									num_q <= 64'(time_tick) + 64'(len) - 64'd1;
									div_go_q <= 1'b1;
									state_q <= ST_DIVT;
								end
							end
							default: state_q <= ST_OUT;
						endcase
						if (action == ACT_CLEAR) begin
							cur_q <= '0;
							obs_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				ST_DIVT: begin
					div_go_q <= 1'b0;
					if (div_done) begin
						if (div_quo > 64'(MAX_PERIODS)) begin
							ovf_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							target_q <= PW'(div_quo);
							cur_q <= cur_q + AW'(1);
							obs_q <= '0;
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					if (mode_q == MODE_ROLL || PW'(32'(cur_q) + 32'd1) >= target_q) begin
						state_q <= ST_RD;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				ST_RD: state_q <= ST_CALC;
				ST_RDW: state_q <= ST_OUT;
				ST_CALC: begin
					old_q <= ram_rdata;
					if (mode_q == MODE_MEAN && cnt_inc[31:0] != 32'd1) begin
						num_q <= mean_num;
						div_go_q <= 1'b1;
						state_q <= ST_DIVM;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_DIVM: begin
					div_go_q <= 1'b0;
					if (div_done) begin
						old_q <= mean_sat;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (act_q == ACT_REPORT) begin
						if (mode_q == MODE_MEAN || mode_q == MODE_COUNT) begin
							obs_q <= cnt_inc[31:0];
						end else begin
							obs_q <= sum_sat;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						read_value <= (act_q == ACT_READ && ridx_ok_q) ? ram_rdata : 32'd0;
						read_valid <= (act_q == ACT_READ && ridx_ok_q);
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) &&
		$stable(read_valid) && $stable(period_count) && $stable(overflow))
		else $error("stalled result changed");
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !out_valid) else $error("config write while busy");
`endif
endmodule
